// ===== hdl/mdc_pkg.sv =====
// shared types, codes and helpers for the motor drive command and current limit unit
package mdc_pkg;

  // request kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_SENSE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SENSE_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd1;

  // bus command codes
  localparam logic [7:0] CMD_ARM_MOTOR  = 8'd1;
  localparam logic [7:0] CMD_READ_MOTOR = 8'd2;
  localparam logic [7:0] CMD_ARM_LIMIT  = 8'd3;
  localparam logic [7:0] CMD_READ_LIMIT = 8'd4;
  localparam logic [7:0] CMD_READ_CUR   = 8'd5;
  localparam logic [7:0] CMD_READ_TEMP  = 8'd6;
  localparam logic [7:0] CMD_READ_ERROR = 8'd7;
  localparam logic [7:0] CMD_READ_HI    = 8'd11;
  localparam logic [7:0] CMD_READ_ADDR  = 8'd12;

  // frame end markers
  localparam logic [7:0] CMD_END = 8'hED;
  localparam logic [7:0] VAL_END = 8'hEC;

  // error codes
  localparam logic [15:0] ERR_NO_FAULT   = 16'd0;
  localparam logic [15:0] ERR_FAULT      = 16'd1;
  localparam logic [15:0] ERR_FAULT_ZERO = 16'd2;

  localparam logic [11:0] LIMIT_RESET  = 12'd1117;
  localparam logic [18:0] LIMIT_T_MAX  = 19'd29791;  // largest 3v+4 whose >>3 is 3723
  localparam logic [15:0] TEMP_OFFSET  = 16'd1100;
  localparam logic [15:0] DIAG_WORD    = 16'h4849;
  localparam logic [4:0]  CUT_NUM      = 5'd30;
  localparam logic [3:0]  CUT_WAIT     = 4'd10;
  localparam logic [3:0]  MS_SAT       = 4'd15;
  localparam logic [4:0]  ADDR_RESET   = 5'd23;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic [11:0] sense_raw;
    logic [11:0] temp_raw;
    logic        driver_fault;
  } in_t;

  typedef struct packed {
    logic [7:0] drive_duty;
    logic       drive_reverse;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       reply_last;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] word;
  } reply_t;

  // (8*v+1)/3 for a 12-bit v, via reciprocal multiply (exact below 2^16)
  function automatic logic [15:0] to_10ma(input logic [11:0] v);
    logic [14:0] x;
    logic [31:0] p;
    begin
      x = {v, 3'b001};
      p = 32'(x) * 32'd43691;
      to_10ma = {1'b0, p[31:17]};
    end
  endfunction

endpackage

// ===== hdl/mdc_query.sv =====
// answer word for the read commands of the bus interface
module mdc_query (
  input  logic [7:0]          cmd,
  input  logic signed [8:0]   motor,
  input  logic [11:0]         limit,
  input  logic [11:0]         filt,
  input  logic [11:0]         temp_raw,
  input  logic                sense_zero,
  input  logic                fault,
  input  logic [4:0]          address,
  output mdc_pkg::reply_t     reply
);

  logic [11:0] scale_in;

  // one divide-by-three input, shared by limit and filtered current reads
  assign scale_in = (cmd == mdc_pkg::CMD_READ_LIMIT) ? limit : filt;

  always_comb begin
    reply.valid = 1'b1;
    reply.word  = 16'd0;
    case (cmd)
      mdc_pkg::CMD_READ_MOTOR: reply.word = {{7{motor[8]}}, motor};
      mdc_pkg::CMD_READ_LIMIT: reply.word = mdc_pkg::to_10ma(scale_in);
      mdc_pkg::CMD_READ_CUR:   reply.word = mdc_pkg::to_10ma(scale_in);
      mdc_pkg::CMD_READ_TEMP:  reply.word = {4'd0, temp_raw} - mdc_pkg::TEMP_OFFSET;
      mdc_pkg::CMD_READ_ERROR: begin
        if (!fault) begin
          reply.word = mdc_pkg::ERR_NO_FAULT;
        end else if (sense_zero) begin
          reply.word = mdc_pkg::ERR_FAULT_ZERO;
        end else begin
          reply.word = mdc_pkg::ERR_FAULT;
        end
      end
      mdc_pkg::CMD_READ_HI:    reply.word = mdc_pkg::DIAG_WORD;
      mdc_pkg::CMD_READ_ADDR:  reply.word = {11'd0, address};
      default:                 reply.valid = 1'b0;
    endcase
  end

endmodule

// ===== hdl/motor_drive_command_and_current_limit_unit.sv =====
// top level: bus command decoder, current filter and current limit with output buffer
// Takes one request per cycle while in_ready is high: bus bytes, current sense
// samples and millisecond ticks. A request is registered, processed by
// combinational logic against the drive state, and its results are written to
// a two-entry output buffer. A query command yields two results (answer high
// byte, then low byte), every other request yields one result with reply_valid
// low. Sustained rate is one request per cycle when each makes one result and
// out_ready is high; a query holds the buffer until both its results are taken,
// so throughput is bounded by the output port. A request passes the input
// register and then the output buffer register before its first result is out.
module motor_drive_command_and_current_limit_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mdc_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mdc_pkg::out_t     out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  // configuration
  logic [7:0] sense_offset;
  logic [4:0] device_address;

  // drive state
  logic [7:0]        byte_window [4];
  logic              pending_motor;
  logic              pending_limit;
  logic signed [8:0] motor_output;
  logic [11:0]       current_limit;
  logic [11:0]       filtered_current;
  logic [3:0]        ms_since_cutback;

  logic              pending_motor_next;
  logic              pending_limit_next;
  logic signed [8:0] motor_output_next;
  logic [11:0]       current_limit_next;
  logic [11:0]       filtered_current_next;
  logic [3:0]        ms_since_cutback_next;

  // input register
  logic         s1_valid;
  mdc_pkg::in_t s1_data;

  // output buffer
  logic          o_valid;
  logic          o_second;
  mdc_pkg::out_t o_item;
  mdc_pkg::out_t o_item2;

  logic fire;
  logic out_load_ok;

  assign out_load_ok = !o_valid || (out_ready && !o_second);
  assign fire        = s1_valid && out_load_ok;
  assign in_ready    = !s1_valid || fire;
  assign out_valid   = o_valid;
  assign out_data    = o_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_offset   <= 8'd0;
      device_address <= mdc_pkg::ADDR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mdc_pkg::CFG_SENSE_OFFSET:   sense_offset   <= cfg_data;
        mdc_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // frame detection over the five-byte window
  logic [7:0]         b0, b1, b2, b3, rx;
  logic               got_cmd, got_val;
  logic signed [15:0] val;
  logic signed [18:0] lim_t;
  logic               motor_in_range;
  logic               limit_ok;

  assign b0 = byte_window[0];
  assign b1 = byte_window[1];
  assign b2 = byte_window[2];
  assign b3 = byte_window[3];
  assign rx = s1_data.rx_byte;

  assign got_cmd        = (b2 == b3) && (rx == mdc_pkg::CMD_END);
  assign got_val        = (b0 == b2) && (b1 == b3) && (rx == mdc_pkg::VAL_END);
  assign val            = {b0, b1};
  assign lim_t          = $signed({{3{val[15]}}, val}) * 19'sd3 + 19'sd4;
  assign motor_in_range = (val <= 16'sd255) && (val >= -16'sd255);
  assign limit_ok       = !lim_t[18] && (lim_t <= $signed(mdc_pkg::LIMIT_T_MAX));

  // sense path
  logic [11:0] cur;
  logic        sense_zero;
  logic [16:0] filt_sum;
  logic [11:0] filt_new;

  assign sense_zero = ({4'd0, sense_offset} >= s1_data.sense_raw);
  assign cur        = sense_zero ? 12'd0 : s1_data.sense_raw - {4'd0, sense_offset};
  assign filt_sum   = {4'd0, filtered_current, 1'b0} + 17'(cur) * 17'(mdc_pkg::CUT_NUM);
  assign filt_new   = filt_sum[16:5];

  // cutback: magnitude scaled by 30/32, rounding toward minus infinity
  logic              motor_neg;
  logic [8:0]        motor_mag;
  logic [13:0]       cut_prod;
  logic [8:0]        cut_mag;
  logic signed [8:0] motor_cut;

  assign motor_neg = motor_output[8];
  assign motor_mag = motor_neg ? 9'(-motor_output) : motor_output;
  assign cut_prod  = 14'(motor_mag) * 14'(mdc_pkg::CUT_NUM) + (motor_neg ? 14'd31 : 14'd0);
  assign cut_mag   = cut_prod[13:5];
  assign motor_cut = motor_neg ? $signed(9'(-cut_mag)) : $signed(cut_mag);

  mdc_pkg::reply_t query;

  mdc_query u_query (
    .cmd        (b3),
    .motor      (motor_output),
    .limit      (current_limit),
    .filt       (filtered_current),
    .temp_raw   (s1_data.temp_raw),
    .sense_zero (sense_zero),
    .fault      (s1_data.driver_fault),
    .address    (device_address),
    .reply      (query)
  );

  logic reply_en;

  always_comb begin
    pending_motor_next    = pending_motor;
    pending_limit_next    = pending_limit;
    motor_output_next     = motor_output;
    current_limit_next    = current_limit;
    filtered_current_next = filtered_current;
    ms_since_cutback_next = ms_since_cutback;
    reply_en              = 1'b0;
    case (s1_data.kind)
      mdc_pkg::KIND_BYTE: begin
        if (got_val && (pending_motor || pending_limit)) begin
          if (pending_motor) begin
            if (motor_in_range) begin
              motor_output_next = val[8:0];
            end
            pending_motor_next = 1'b0;
          end else begin
            if (limit_ok) begin
              current_limit_next = lim_t[14:3];
            end
            pending_limit_next = 1'b0;
          end
        end else if (got_cmd || got_val) begin
          pending_motor_next = (b3 == mdc_pkg::CMD_ARM_MOTOR);
          pending_limit_next = (b3 == mdc_pkg::CMD_ARM_LIMIT);
          reply_en           = query.valid;
        end
      end
      mdc_pkg::KIND_SENSE: begin
        if (motor_output == 9'sd0) begin
          filtered_current_next = 12'd0;
        end else begin
          filtered_current_next = filt_new;
          if (ms_since_cutback >= mdc_pkg::CUT_WAIT) begin
            ms_since_cutback_next = 4'd0;
            if (filt_new > current_limit) begin
              motor_output_next = motor_cut;
            end
          end
        end
      end
      mdc_pkg::KIND_TICK: begin
        if (ms_since_cutback < mdc_pkg::MS_SAT) begin
          ms_since_cutback_next = ms_since_cutback + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window[0]   <= 8'd0;
      byte_window[1]   <= 8'd0;
      byte_window[2]   <= 8'd0;
      byte_window[3]   <= 8'd0;
      pending_motor    <= 1'b0;
      pending_limit    <= 1'b0;
      motor_output     <= 9'sd0;
      current_limit    <= mdc_pkg::LIMIT_RESET;
      filtered_current <= 12'd0;
      ms_since_cutback <= 4'd0;
    end else if (fire) begin
      if (s1_data.kind == mdc_pkg::KIND_BYTE) begin
        byte_window[0] <= b1;
        byte_window[1] <= b2;
        byte_window[2] <= b3;
        byte_window[3] <= rx;
      end
      pending_motor    <= pending_motor_next;
      pending_limit    <= pending_limit_next;
      motor_output     <= motor_output_next;
      current_limit    <= current_limit_next;
      filtered_current <= filtered_current_next;
      ms_since_cutback <= ms_since_cutback_next;
    end
  end

  // result items
  logic [8:0]    duty_mag;
  mdc_pkg::out_t first_item;
  mdc_pkg::out_t second_item;

  assign duty_mag = motor_output_next[8] ? 9'(-motor_output_next) : motor_output_next;

  always_comb begin
    first_item.drive_duty    = duty_mag[7:0];
    first_item.drive_reverse = motor_output_next[8];
    first_item.reply_valid   = reply_en;
    first_item.reply_byte    = reply_en ? query.word[15:8] : 8'd0;
    first_item.reply_last    = !reply_en;
    second_item.drive_duty    = duty_mag[7:0];
    second_item.drive_reverse = motor_output_next[8];
    second_item.reply_valid   = 1'b1;
    second_item.reply_byte    = query.word[7:0];
    second_item.reply_last    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      o_second <= 1'b0;
    end else if (fire) begin
      o_valid  <= 1'b1;
      o_second <= reply_en;
    end else if (o_valid && out_ready) begin
      if (o_second) begin
        o_second <= 1'b0;
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_item  <= first_item;
      o_item2 <= second_item;
    end else if (o_valid && out_ready && o_second) begin
      o_item <= o_item2;
    end
  end

endmodule

// ===== hdl/mdc_checker.sv =====
// port-level checks for the motor drive command and current limit unit
module mdc_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input mdc_pkg::out_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a non-final result is always the high answer byte, so it carries a reply
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.reply_last |-> out_data.reply_valid)
    else $error("non-final result without reply");

  // the low answer byte follows right after the high byte is taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.reply_last |=>
      out_valid && out_data.reply_valid && out_data.reply_last)
    else $error("second answer byte missing");

  // no reply means a zero reply byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.reply_valid |-> out_data.reply_byte == 8'd0)
    else $error("reply byte set without reply");

  // reverse only with a nonzero duty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_reverse |-> out_data.drive_duty != 8'd0)
    else $error("reverse with zero duty");

endmodule

bind motor_drive_command_and_current_limit_unit mdc_checker u_mdc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
